@@ design/raw_pixel_unpacker_defines.svh @@
// ----------------------------------------------------------------------------
// Raw pixel unpacker assertion macros
// Helpers for the concurrent checks of the unpacker queue module.
// ----------------------------------------------------------------------------
`ifndef RAW_PIXEL_UNPACKER_DEFINES_SVH
`define RAW_PIXEL_UNPACKER_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define RPU_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a consequence in the same cycle as its trigger.
`define RPU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger.
`define RPU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/rpu_pkg.sv @@
// ----------------------------------------------------------------------------
// rpu_pkg
// Types, constants and tables shared by the raw pixel unpacker modules.
// ----------------------------------------------------------------------------
package rpu_pkg;

  localparam int MAX_LINE_PIXELS_DEF  = 8192;
  localparam int MAX_STRIDE_BYTES_DEF = 32768;
  localparam int LINE_INDEX_LIMIT     = 8192;

  localparam int PIX_W      = 16;
  localparam int COL_W      = 13;
  localparam int LINE_IDX_W = 13;
  localparam int LINES_W    = 14;
  localparam int ACC_W      = 32;
  localparam int LANES      = 4;
  localparam int CNT_W      = 3;
  localparam int GQ_DEPTH   = 4;

  // register map, word index = paddr[4:2]
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  typedef enum logic [2:0] {
    REG_PACK_MODE   = 3'd0,
    REG_SAMPLE_BITS = 3'd1,
    REG_LINE_PIXELS = 3'd2,
    REG_LINE_STRIDE = 3'd3,
    REG_FRAME_LINES = 3'd4
  } rpu_reg_idx_t;

  localparam logic [1:0] MODE_RAW10 = 2'd0;
  localparam logic [1:0] MODE_RAW12 = 2'd1;

  localparam logic [1:0]  PACK_MODE_RST   = MODE_RAW10;
  localparam logic [4:0]  SAMPLE_BITS_RST = 5'd10;
  localparam logic [13:0] LINE_PIXELS_RST = 14'd1920;
  localparam logic [15:0] LINE_STRIDE_RST = 16'd2400;
  localparam logic [13:0] FRAME_LINES_RST = 14'd1080;

  localparam logic [3:0] RAW12_LAST_PHASE = 4'd15;
  localparam logic [3:0] RAW10_LOW_PHASE  = 4'd4;

  typedef struct packed {
    logic [1:0]  pack_mode;
    logic [4:0]  sample_bits;
    logic [13:0] line_pixels;
    logic [15:0] line_stride_bytes;
    logic [13:0] frame_lines;
  } rpu_cfg_t;

  // up to four pixels decoded from one byte
  typedef struct packed {
    logic [LANES-1:0][PIX_W-1:0] value;
    logic [COL_W-1:0]            col;
    logic [CNT_W-1:0]            cnt;
    logic                        le_last;
    logic                        fe_last;
  } rpu_group_t;

  // bit position at which a RAW12 burst byte lands in the accumulator
  function automatic logic [4:0] raw12_held(input logic [3:0] ph);
    logic [4:0] held;
    unique case (ph) inside
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: held = 5'd0;
      4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       held = 5'd8;
      default:                              held = 5'd4;
    endcase
    return held;
  endfunction

endpackage

@@ design/rpu_regs.sv @@
// ----------------------------------------------------------------------------
// rpu_regs
// APB-style configuration registers of the raw pixel unpacker.
// ----------------------------------------------------------------------------
module rpu_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rpu_pkg::PADDR_W-1:0] paddr,
  input  logic [rpu_pkg::PDATA_W-1:0] pwdata,
  output logic [rpu_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output rpu_pkg::rpu_cfg_t           cfg
);
  import rpu_pkg::*;

  rpu_cfg_t     cfg_r, cfg_nxt;
  rpu_reg_idx_t idx;
  logic         wr_en;

  assign idx    = rpu_reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_PACK_MODE:   cfg_nxt.pack_mode         = pwdata[1:0];
        REG_SAMPLE_BITS: cfg_nxt.sample_bits       = pwdata[4:0];
        REG_LINE_PIXELS: cfg_nxt.line_pixels       = pwdata[13:0];
        REG_LINE_STRIDE: cfg_nxt.line_stride_bytes = pwdata[15:0];
        REG_FRAME_LINES: cfg_nxt.frame_lines       = pwdata[13:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PACK_MODE:   prdata = PDATA_W'(cfg_r.pack_mode);
      REG_SAMPLE_BITS: prdata = PDATA_W'(cfg_r.sample_bits);
      REG_LINE_PIXELS: prdata = PDATA_W'(cfg_r.line_pixels);
      REG_LINE_STRIDE: prdata = PDATA_W'(cfg_r.line_stride_bytes);
      REG_FRAME_LINES: prdata = PDATA_W'(cfg_r.frame_lines);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pack_mode         <= PACK_MODE_RST;
      cfg_r.sample_bits       <= SAMPLE_BITS_RST;
      cfg_r.line_pixels       <= LINE_PIXELS_RST;
      cfg_r.line_stride_bytes <= LINE_STRIDE_RST;
      cfg_r.frame_lines       <= FRAME_LINES_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ design/rpu_front.sv @@
// ----------------------------------------------------------------------------
// rpu_front
// Byte decoder: gathers bytes, forms pixel groups, tracks line and frame.
// ----------------------------------------------------------------------------
module rpu_front #(
  parameter int MAX_LINE_PIXELS  = rpu_pkg::MAX_LINE_PIXELS_DEF,
  parameter int MAX_STRIDE_BYTES = rpu_pkg::MAX_STRIDE_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rpu_pkg::rpu_cfg_t  cfg,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  output logic               grp_wr,
  output rpu_pkg::rpu_group_t grp
);
  import rpu_pkg::*;

  localparam int PW = $clog2(MAX_LINE_PIXELS + 1);
  localparam int SW = $clog2(MAX_STRIDE_BYTES + 1);

  logic [SW-1:0]         bil_r, bil_nxt;
  logic [PW-1:0]         pil_r, pil_nxt;
  logic [LINE_IDX_W-1:0] li_r, li_nxt;
  logic [3:0]            phase_r, phase_nxt;
  logic [ACC_W-1:0]      acc_r, acc_nxt;

  logic [PW-1:0]      eff_w;
  logic [SW-1:0]      eff_s;
  logic [LINES_W-1:0] eff_l;
  logic [15:0]        stride_nz;
  logic [LINES_W-1:0] lines_nz;

  logic [LANES-1:0][PIX_W-1:0] vals;
  logic [CNT_W-1:0]            cand;
  logic [ACC_W-1:0]            acc_dec;
  logic [3:0]                  phase_dec;
  logic [PW-1:0]               rem;
  logic [CNT_W-1:0]            n;
  logic [SW-1:0]               bil_inc;
  logic [LINES_W-1:0]          li_inc;

  // clamp the programmed sizes
  always_comb begin
    stride_nz = (cfg.line_stride_bytes == 16'd0) ? 16'd1 : cfg.line_stride_bytes;
    lines_nz  = (cfg.frame_lines == 14'd0) ? 14'd1 : cfg.frame_lines;
    eff_w = (32'(cfg.line_pixels) > MAX_LINE_PIXELS) ? PW'(MAX_LINE_PIXELS)
                                                      : PW'(cfg.line_pixels);
    eff_s = (32'(stride_nz) > MAX_STRIDE_BYTES) ? SW'(MAX_STRIDE_BYTES) : SW'(stride_nz);
    eff_l = (lines_nz > LINES_W'(LINE_INDEX_LIMIT)) ? LINES_W'(LINE_INDEX_LIMIT) : lines_nz;
  end

  // decode one byte
  always_comb begin
    logic [ACC_W-1:0] b32;
    logic [ACC_W-1:0] accb;
    logic [4:0]       held;
    logic [15:0]      sample;
    logic [4:0]       shift;
    logic [31:0]      shifted;
    b32       = ACC_W'(data_byte);
    accb      = '0;
    held      = '0;
    sample    = '0;
    shift     = '0;
    shifted   = '0;
    vals      = '0;
    cand      = '0;
    acc_dec   = '0;
    phase_dec = '0;
    case (cfg.pack_mode)
      MODE_RAW10: begin
        if (phase_r < RAW10_LOW_PHASE) begin
          acc_dec   = acc_r | (b32 << {phase_r[1:0], 3'b000});
          phase_dec = phase_r + 4'd1;
        end else begin
          for (int k = 0; k < LANES; k++) begin
            vals[k] = {acc_r[8*k +: 8], data_byte[2*k +: 2], 6'd0};
          end
          cand = CNT_W'(LANES);
        end
      end
      MODE_RAW12: begin
        if (phase_r != RAW12_LAST_PHASE) begin
          held = raw12_held(phase_r);
          accb = acc_r | (b32 << held);
          if (held >= 5'd4) begin
            vals[0] = {accb[11:0], 4'd0};
            cand    = CNT_W'(1);
            acc_dec = accb >> 12;
          end else begin
            acc_dec = accb;
          end
          phase_dec = phase_r + 4'd1;
        end
      end
      default: begin
        if (phase_r == 4'd0) begin
          acc_dec   = b32;
          phase_dec = 4'd1;
        end else begin
          sample  = {data_byte, acc_r[7:0]};
          shift   = (cfg.sample_bits > 5'd16) ? 5'd0 : 5'd16 - cfg.sample_bits;
          shifted = {16'd0, sample} << shift;
          vals[0] = shifted[15:0];
          cand    = CNT_W'(1);
        end
      end
    endcase
  end

  // suppress pixels past the line width, then advance the position
  always_comb begin
    // a width lowered mid-line can leave the position at or past the line end
    rem     = (pil_r >= eff_w) ? '0 : eff_w - pil_r;
    n       = (rem >= PW'(cand)) ? cand : rem[CNT_W-1:0];
    bil_inc = bil_r + SW'(1);
    li_inc  = {1'b0, li_r} + LINES_W'(1);

    grp.value   = vals;
    grp.col     = COL_W'(pil_r);
    grp.cnt     = n;
    grp.le_last = (PW'(n) == rem);
    grp.fe_last = (PW'(n) == rem) && (li_inc >= eff_l);
    grp_wr      = accept && (n != '0);

    bil_nxt   = bil_r;
    pil_nxt   = pil_r;
    li_nxt    = li_r;
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    if (accept) begin
      phase_nxt = phase_dec;
      acc_nxt   = acc_dec;
      pil_nxt   = pil_r + PW'(n);
      bil_nxt   = bil_inc;
      if (bil_inc >= eff_s) begin
        bil_nxt   = '0;
        pil_nxt   = '0;
        phase_nxt = '0;
        acc_nxt   = '0;
        li_nxt    = (li_inc >= eff_l) ? '0 : li_inc[LINE_IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bil_r   <= '0;
      pil_r   <= '0;
      li_r    <= '0;
      phase_r <= '0;
      acc_r   <= '0;
    end else begin
      bil_r   <= bil_nxt;
      pil_r   <= pil_nxt;
      li_r    <= li_nxt;
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
    end
  end

endmodule

@@ design/rpu_queue.sv @@
// ----------------------------------------------------------------------------
// rpu_queue
// Short queue of pixel groups between the decoder and the output side.
// ----------------------------------------------------------------------------
module rpu_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  rpu_pkg::rpu_group_t wr_grp,
  input  logic                rd_en,
  output rpu_pkg::rpu_group_t rd_grp,
  output logic                full,
  output logic                empty
);
  import rpu_pkg::*;

  localparam int PTR_W = $clog2(GQ_DEPTH);
  localparam int QC_W  = $clog2(GQ_DEPTH + 1);

  rpu_group_t       grp_r [GQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0]  count_r, count_nxt;

  assign full   = (count_r == QC_W'(GQ_DEPTH));
  assign empty  = (count_r == '0);
  assign rd_grp = grp_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(GQ_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(GQ_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({wr_en, rd_en})
      2'b10:   count_nxt = count_r + QC_W'(1);
      2'b01:   count_nxt = count_r - QC_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      grp_r[wr_ptr_r] <= wr_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`include "raw_pixel_unpacker_defines.svh"

  `RPU_ASSERT_SAME(a_no_overflow, wr_en, count_r < QC_W'(GQ_DEPTH), "group written into a full queue")
  `RPU_ASSERT_SAME(a_no_underflow, rd_en, count_r != '0, "group read from an empty queue")
  `RPU_ASSERT_NEXT(a_count_up, wr_en && !rd_en, count_r == $past(count_r) + QC_W'(1), "queue count lost a write")

endmodule

@@ design/rpu_back.sv @@
// ----------------------------------------------------------------------------
// rpu_back
// Output side: walks the pixels of the head group, one per pop.
// ----------------------------------------------------------------------------
module rpu_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rpu_pkg::rpu_group_t          head,
  input  logic                         q_empty,
  output logic                         q_rd,
  input  logic                         pop,
  output logic                         empty,
  output logic [rpu_pkg::PIX_W-1:0]    pixel_value,
  output logic [rpu_pkg::COL_W-1:0]    column,
  output logic                         line_end,
  output logic                         frame_end,
  output logic                         run_last
);
  import rpu_pkg::*;

  localparam int IDX_W = $clog2(LANES);

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             last;

  assign last        = ({1'b0, idx_r} == (head.cnt - CNT_W'(1)));
  assign empty       = q_empty;
  assign pixel_value = head.value[idx_r];
  assign column      = head.col + COL_W'(idx_r);
  assign line_end    = last && head.le_last;
  assign frame_end   = last && head.fe_last;
  assign run_last    = last;
  assign q_rd        = pop && !q_empty && last;

  always_comb begin
    idx_nxt = idx_r;
    if (pop && !q_empty) begin
      idx_nxt = last ? '0 : idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

@@ design/raw_pixel_unpacker.sv @@
// A byte that completes pixels writes its group into the queue register; its
//   pixels then reach the result ports from the queue head, one per pop.
// Throughput: one byte per cycle while the queue has room; one pixel per cycle
//   out while popped, set by the walk over a group (four for a RAW10 low byte).
// Reset (synchronous, rst_n low): clears line, frame and queue state and loads
//   the register defaults; the first byte may follow on the next cycle.
// ----------------------------------------------------------------------------
// raw_pixel_unpacker
// Unpacks RAW10, burst RAW12 and 16-bit raw buffers into left-aligned pixels.
// ----------------------------------------------------------------------------
module raw_pixel_unpacker #(
  parameter int MAX_LINE_PIXELS  = rpu_pkg::MAX_LINE_PIXELS_DEF,
  parameter int MAX_STRIDE_BYTES = rpu_pkg::MAX_STRIDE_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel: one buffer byte per request
  input  logic                        push,
  output logic                        full,
  input  logic [7:0]                  in_data_byte,
  // result channel: one pixel per request
  output logic                        empty,
  input  logic                        pop,
  output logic [rpu_pkg::PIX_W-1:0]   out_pixel_value,
  output logic [rpu_pkg::COL_W-1:0]   out_column,
  output logic                        out_line_end,
  output logic                        out_frame_end,
  output logic                        out_run_last,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rpu_pkg::PADDR_W-1:0] paddr,
  input  logic [rpu_pkg::PDATA_W-1:0] pwdata,
  output logic [rpu_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import rpu_pkg::*;

  rpu_cfg_t   cfg;
  rpu_group_t wr_grp;
  rpu_group_t head_grp;
  logic       accept;
  logic       grp_wr;
  logic       grp_rd;
  logic       q_full;
  logic       q_empty;

  // take a byte whenever the group queue has room; the decoder never waits
  // on the output side directly
  assign accept = push && !q_full;
  assign full   = q_full;

  rpu_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // front: gather bytes, decode, drop padding and overrun pixels
  rpu_front #(
    .MAX_LINE_PIXELS  (MAX_LINE_PIXELS),
    .MAX_STRIDE_BYTES (MAX_STRIDE_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .accept    (accept),
    .data_byte (in_data_byte),
    .grp_wr    (grp_wr),
    .grp       (wr_grp)
  );

  // hold decoded groups until the output side drains them
  rpu_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (grp_wr),
    .wr_grp (wr_grp),
    .rd_en  (grp_rd),
    .rd_grp (head_grp),
    .full   (q_full),
    .empty  (q_empty)
  );

  // back: advance through the head group one pixel per pop, drop it after
  // its last pixel
  rpu_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head_grp),
    .q_empty     (q_empty),
    .q_rd        (grp_rd),
    .pop         (pop),
    .empty       (empty),
    .pixel_value (out_pixel_value),
    .column      (out_column),
    .line_end    (out_line_end),
    .frame_end   (out_frame_end),
    .run_last    (out_run_last)
  );

endmodule
